FILE: hdl/mqsb_pkg.sv
// mqsb_pkg: sizes, field widths and command/status codes for the shared-buffer queues
// no dependencies; imported by multi_queue_shared_buffer

package mqsb_pkg;

    localparam int NUM_SLOTS  = 64;
    localparam int NUM_QUEUES = 8;
    localparam int DATA_WIDTH = 32;

    localparam int SLOT_W   = $clog2(NUM_SLOTS);
    localparam int QUEUE_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int COUNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int MODE_W   = 2;
    localparam int QID_W    = 4;
    localparam int STATUS_W = 2;

    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [QUEUE_W-1:0]  t_queue;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [QID_W-1:0]    t_qid;
    typedef logic [STATUS_W-1:0] t_status;

    // command codes
    localparam t_mode MODE_PUSH = 2'd0;
    localparam t_mode MODE_POP  = 2'd1;
    localparam t_mode MODE_PEEK = 2'd2;

    // result codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // link value of a slot that was never written since reset
    function automatic t_slot reset_link(input t_slot s);
        t_slot r;
        if (int'(s) == NUM_SLOTS - 1) begin
            r = '0;
        end else begin
            r = s + t_slot'(1);
        end
        return r;
    endfunction

endpackage

FILE: hdl/multi_queue_shared_buffer.sv
// multi_queue_shared_buffer: fifo queues sharing one slot store via a link memory and free list
// depends on mqsb_pkg (sizes, codes, reset_link)
//
//  channel   direction  handshake                 word fields
//  -------   ---------  ------------------------  --------------------------------------
//  in        input      i_in_valid / o_in_stall   i_mode, i_queue_id, i_data_in
//  out       output     o_out_valid / i_out_stall o_status, o_head_value, o_slot_index
//
// one word per cycle sustained while i_out_stall is low; a word moves from the input register
// to the result register, whose valid flag drives o_out_valid
// the link and data memories are read when a word is accepted, at addresses taken from the
// queue state as it will be after the word ahead of it; a write in that same cycle is forwarded
// reset clears queue state and link valid bits at once: words are taken right after reset
// o_in_stall rises only when the input register holds a word and the result register is full
// and stalled; the result register keeps its word until taken

module multi_queue_shared_buffer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  mqsb_pkg::t_mode                      i_mode,
    input  mqsb_pkg::t_qid                       i_queue_id,
    input  logic signed [mqsb_pkg::DATA_WIDTH-1:0] i_data_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output mqsb_pkg::t_status                    o_status,
    output logic signed [mqsb_pkg::DATA_WIDTH-1:0] o_head_value,
    output mqsb_pkg::t_slot                      o_slot_index
);
    import mqsb_pkg::*;

    // queue and free-list state
    t_slot             r_q_head [NUM_QUEUES];
    t_slot             n_q_head [NUM_QUEUES];
    t_slot             r_q_tail [NUM_QUEUES];
    t_slot             n_q_tail [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_q_nonempty, n_q_nonempty;
    t_slot             r_free_head, n_free_head;
    t_count            r_free_count, n_free_count;

    // input register
    logic              r_in_valid;
    t_mode             r_in_mode;
    t_qid              r_in_qid;
    logic [DATA_WIDTH-1:0] r_in_data;

    // result register
    logic              r_out_valid;
    t_status           r_status, n_status;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    t_slot             r_slot, n_slot;

    // link memory with per-entry valid bits, data memory without
    t_slot             r_link_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_link_vld;
    t_slot             r_link_q, r_link_ra, r_link_fwd_d;
    logic              r_link_fwd, r_link_vld_q;
    logic [DATA_WIDTH-1:0] r_data_mem [NUM_SLOTS];
    logic [DATA_WIDTH-1:0] r_data_q, r_data_fwd_d;
    logic              r_data_fwd;

    logic              link_we, data_we;
    t_slot             link_wa, link_wd, data_wa, link_ra, data_ra;
    logic [DATA_WIDTH-1:0] data_wd;
    t_slot             link_rd;
    logic [DATA_WIDTH-1:0] data_rd;

    logic              advance, proc, in_accept, valid_q;
    t_queue            q, q_new;
    t_slot             s_sel;

    // handshake: the input register moves on whenever the result register can load
    assign advance    = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // resolve the prefetched memory words: forwarded write, then stored entry, then reset link for the link word
    assign link_rd = r_link_fwd ? r_link_fwd_d :
                     (r_link_vld_q ? r_link_q : reset_link(r_link_ra));
    assign data_rd = r_data_fwd ? r_data_fwd_d : r_data_q;

    assign valid_q = (r_in_qid >= QID_W'(1)) && (int'(r_in_qid) <= NUM_QUEUES);
    assign q       = QUEUE_W'(r_in_qid - QID_W'(1));

    // command execution on the word held in the input register
    always_comb begin
        n_q_head     = r_q_head;
        n_q_tail     = r_q_tail;
        n_q_nonempty = r_q_nonempty;
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        link_we      = 1'b0;
        link_wa      = '0;
        link_wd      = '0;
        data_we      = 1'b0;
        data_wa      = r_free_head;
        data_wd      = r_in_data;
        n_status     = ST_OK;
        n_value      = '0;
        n_slot       = '0;
        s_sel        = r_q_head[q];
        if (proc) begin
            case (r_in_mode)
                MODE_PUSH: begin
                    if (!valid_q || r_free_count == '0) begin
                        n_status = ST_FULL;
                    end else begin
                        // take the free-list head; the new tail's own link is never followed
                        n_free_head  = link_rd;
                        n_free_count = r_free_count - t_count'(1);
                        if (r_q_nonempty[q]) begin
                            link_we = 1'b1;
                            link_wa = r_q_tail[q];
                            link_wd = r_free_head;
                        end else begin
                            n_q_head[q]     = r_free_head;
                            n_q_nonempty[q] = 1'b1;
                        end
                        n_q_tail[q] = r_free_head;
                        data_we     = 1'b1;
                        n_slot      = r_free_head;
                    end
                end
                MODE_POP: begin
                    if (!valid_q || !r_q_nonempty[q]) begin
                        n_status = ST_EMPTY;
                    end else begin
                        if (s_sel == r_q_tail[q]) begin
                            n_q_nonempty[q] = 1'b0;
                        end else begin
                            n_q_head[q] = link_rd;
                        end
                        // freed slot goes to the front of the free list
                        link_we      = 1'b1;
                        link_wa      = s_sel;
                        link_wd      = r_free_head;
                        n_free_head  = s_sel;
                        n_free_count = r_free_count + t_count'(1);
                    end
                end
                MODE_PEEK: begin
                    if (!valid_q || !r_q_nonempty[q]) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_value = data_rd;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // read addresses for the incoming word, from the state after the current one
    assign q_new   = QUEUE_W'(i_queue_id - QID_W'(1));
    assign link_ra = (i_mode == MODE_PUSH) ? n_free_head : n_q_head[q_new];
    assign data_ra = n_q_head[q_new];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_q_head[i] <= '0;
                r_q_tail[i] <= '0;
            end
            r_q_nonempty <= '0;
            r_free_head  <= '0;
            r_free_count <= t_count'(NUM_SLOTS);
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_link_vld   <= '0;
        end else begin
            r_q_head     <= n_q_head;
            r_q_tail     <= n_q_tail;
            r_q_nonempty <= n_q_nonempty;
            r_free_head  <= n_free_head;
            r_free_count <= n_free_count;
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (link_we) begin
                r_link_vld[link_wa] <= 1'b1;
            end
        end
    end

    // input and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_mode <= i_mode;
            r_in_qid  <= i_queue_id;
            r_in_data <= i_data_in;
        end
        if (proc) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_slot   <= n_slot;
        end
    end

    // link memory: one write, one registered read with write forwarding
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_wa] <= link_wd;
        end
        if (in_accept) begin
            r_link_q     <= r_link_mem[link_ra];
            r_link_vld_q <= r_link_vld[link_ra];
            r_link_ra    <= link_ra;
            r_link_fwd   <= link_we && (link_wa == link_ra);
            r_link_fwd_d <= link_wd;
        end
    end

    // data memory: same arrangement
    always_ff @(posedge i_clk) begin
        if (data_we) begin
            r_data_mem[data_wa] <= data_wd;
        end
        if (in_accept) begin
            r_data_q     <= r_data_mem[data_ra];
            r_data_fwd   <= data_we && (data_wa == data_ra);
            r_data_fwd_d <= data_wd;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_head_value = r_value;
    assign o_slot_index = r_slot;

    // free slots never exceed the store
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_free_count) <= NUM_SLOTS)
        else $error("free count above slot count");

    // every nonempty queue holds at least one slot taken from the free list
    a_slot_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_q_nonempty) + int'(r_free_count)) <= NUM_SLOTS)
        else $error("nonempty queues exceed used slots");

    // an executed word shows up as a result on the next edge
    a_proc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> r_out_valid)
        else $error("executed word lost");

    // free count stays put unless a word is executed
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !proc |=> $stable(r_free_count))
        else $error("free count changed without a word");

endmodule
